// ===== rtl/hex_gene_stream_validator_core_assert.svh =====
// assertion macros shared by the validator modules
// each expects clk and rst_n in the enclosing module
`ifndef HEX_GENE_STREAM_VALIDATOR_CORE_ASSERT_SVH
`define HEX_GENE_STREAM_VALIDATOR_CORE_ASSERT_SVH

// same-cycle implication
`define HGSV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HGSV_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hgsv_pkg.sv =====
`timescale 1ns / 1ps

package hgsv_pkg;

  // stripped text limit
  localparam int MAX_LEN = 65536;
  localparam int POS_W   = 17;
  localparam int IDX_W   = 16;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

  // result queue
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // characters of interest
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;

  // result kinds
  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_END   = 2'd1;
  localparam logic [1:0] EV_OK    = 2'd2;
  localparam logic [1:0] EV_BAD   = 2'd3;

  // opcode classes
  localparam logic [1:0] CLS_PLAIN    = 2'd0;
  localparam logic [1:0] CLS_RESTRICT = 2'd1;
  localparam logic [1:0] CLS_COLOUR   = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_BODY = 5'b00010,
    PH_OPER = 5'b00100,
    PH_SKIP = 5'b01000,
    PH_HALT = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]       event_kind;
    logic [POS_W-1:0] position;
    logic [IDX_W-1:0] gene_index;
    logic             final_result;
  } res_t;

  // up to two result words per byte: gene event, then status
  typedef struct packed {
    logic ev0_valid;
    res_t ev0;
    logic ev1_valid;
    res_t ev1;
  } push_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    begin
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
    end
  endfunction

endpackage

// ===== rtl/hgsv_if.sv =====
`timescale 1ns / 1ps

// byte input channel
interface hgsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;
  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

// result channel
interface hgsv_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     event_kind;
  logic [hgsv_pkg::POS_W-1:0]     position;
  logic [hgsv_pkg::IDX_W-1:0]     gene_index;
  logic                           final_result;
  modport source (output valid, output event_kind, output position, output gene_index,
                  output final_result, input ready);
  modport sink   (input valid, input event_kind, input position, input gene_index,
                  input final_result, output ready);
endinterface

// ===== rtl/hgsv_parse.sv =====
`timescale 1ns / 1ps
`include "hex_gene_stream_validator_core_assert.svh"

module hgsv_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  logic [7:0]           char_in,
  input  logic                 last_char,
  output hgsv_pkg::push_t      push
);

  logic                        in_comment_r, in_comment_nxt;
  logic [hgsv_pkg::POS_W-1:0]  cnt_r, cnt_nxt;
  hgsv_pkg::phase_t            phase_r, phase_nxt;
  logic [1:0]                  cls_r, cls_nxt;
  logic [1:0]                  ops_r, ops_nxt;
  logic [hgsv_pkg::POS_W-1:0]  skip_r, skip_nxt;
  logic                        bad_r, bad_nxt;
  logic [hgsv_pkg::POS_W-1:0]  bad_pos_r, bad_pos_nxt;
  logic [hgsv_pkg::POS_W-1:0]  serr_r, serr_nxt;
  logic [hgsv_pkg::IDX_W-1:0]  genes_r, genes_nxt;

  logic [4:0] hv;
  logic [3:0] v;
  logic       is_hex;
  logic       is_ws;
  logic       body_act;
  logic       oper_act;
  logic [2:0] span;

  assign hv     = hgsv_pkg::hex_decode(char_in);
  assign v      = hv[3:0];
  assign is_hex = hv[4];
  assign is_ws  = (char_in == hgsv_pkg::CH_SPACE) || (char_in == hgsv_pkg::CH_CR) ||
                  (char_in == hgsv_pkg::CH_LF);

  // strip, hex check, gene parse and status for one byte
  always_comb begin
    in_comment_nxt = in_comment_r;
    cnt_nxt        = cnt_r;
    phase_nxt      = phase_r;
    cls_nxt        = cls_r;
    ops_nxt        = ops_r;
    skip_nxt       = skip_r;
    bad_nxt        = bad_r;
    bad_pos_nxt    = bad_pos_r;
    serr_nxt       = serr_r;
    genes_nxt      = genes_r;
    push           = '0;
    body_act       = 1'b0;
    oper_act       = 1'b0;
    span           = 3'd0;

    if (item_valid) begin
      if (in_comment_r) begin
        if (char_in == hgsv_pkg::CH_RPAREN) in_comment_nxt = 1'b0;
      end else if (char_in == hgsv_pkg::CH_LPAREN) begin
        in_comment_nxt = 1'b1;
      end else if (!is_ws) begin
        if (cnt_r >= hgsv_pkg::MAX_POS) begin
          cnt_nxt = hgsv_pkg::MAX_POS + 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          if (!is_hex) begin
            if (!bad_r) begin
              bad_nxt     = 1'b1;
              bad_pos_nxt = cnt_r;
            end
          end else if (!bad_r) begin
            // phase dispatch
            unique case (phase_r)
              hgsv_pkg::PH_IDLE: begin
                if (v == 4'd0) begin
                  push.ev0_valid             = 1'b1;
                  push.ev0.event_kind        = hgsv_pkg::EV_START;
                  push.ev0.position          = cnt_r;
                  push.ev0.gene_index        = genes_r;
                  phase_nxt                  = hgsv_pkg::PH_BODY;
                end
              end
              hgsv_pkg::PH_BODY: body_act = 1'b1;
              hgsv_pkg::PH_OPER: oper_act = 1'b1;
              hgsv_pkg::PH_SKIP: begin
                if (cnt_r == skip_r) begin
                  if (ops_r != 2'd0) begin
                    oper_act = 1'b1;
                  end else if (cls_r == hgsv_pkg::CLS_RESTRICT &&
                               (v == 4'd1 || v >= 4'hc)) begin
                    serr_nxt  = cnt_r;
                    phase_nxt = hgsv_pkg::PH_HALT;
                  end else begin
                    body_act = 1'b1;
                  end
                end
              end
              default: ;
            endcase

            // opcode position
            if (body_act) begin
              if (v == 4'd1) begin
                push.ev0_valid      = 1'b1;
                push.ev0.event_kind = hgsv_pkg::EV_END;
                push.ev0.position   = cnt_r + 1'b1;
                push.ev0.gene_index = genes_r;
                genes_nxt           = genes_r + 1'b1;
                phase_nxt           = hgsv_pkg::PH_IDLE;
              end else if (v == 4'd0) begin
                serr_nxt  = cnt_r;
                phase_nxt = hgsv_pkg::PH_HALT;
              end else begin
                phase_nxt = hgsv_pkg::PH_OPER;
                unique case (v) inside
                  4'hc: begin
                    cls_nxt = hgsv_pkg::CLS_RESTRICT;
                    ops_nxt = 2'd1;
                  end
                  4'hd, 4'he, 4'hf: begin
                    cls_nxt = hgsv_pkg::CLS_RESTRICT;
                    ops_nxt = 2'd2;
                  end
                  4'h3, 4'hb: begin
                    cls_nxt = hgsv_pkg::CLS_PLAIN;
                    ops_nxt = 2'd3;
                  end
                  4'ha: begin
                    cls_nxt = hgsv_pkg::CLS_PLAIN;
                    ops_nxt = 2'd2;
                  end
                  4'h5, 4'h6: begin
                    cls_nxt = hgsv_pkg::CLS_COLOUR;
                    ops_nxt = 2'd1;
                  end
                  default: begin
                    cls_nxt = hgsv_pkg::CLS_PLAIN;
                    ops_nxt = 2'd1;
                  end
                endcase
              end
            end

            // operand marker
            if (oper_act) begin
              if (v == 4'd2)                 span = (cls_r == hgsv_pkg::CLS_COLOUR) ? 3'd7 : 3'd5;
              else if (v == 4'd3)            span = 3'd5;
              else if (v == 4'd0 || v == 4'd1) span = 3'd1;
              if (span == 3'd0) begin
                serr_nxt  = cnt_r;
                phase_nxt = hgsv_pkg::PH_HALT;
              end else begin
                ops_nxt   = ops_r - 2'd1;
                skip_nxt  = cnt_r + hgsv_pkg::POS_W'(span);
                phase_nxt = hgsv_pkg::PH_SKIP;
              end
            end
          end
        end
      end

      // closing status word, then back to reset state
      if (last_char) begin
        push.ev1_valid        = 1'b1;
        push.ev1.final_result = 1'b1;
        push.ev1.event_kind   = hgsv_pkg::EV_BAD;
        if (cnt_nxt > hgsv_pkg::MAX_POS)          push.ev1.position = hgsv_pkg::MAX_POS;
        else if (bad_nxt)                         push.ev1.position = bad_pos_nxt;
        else if (phase_nxt == hgsv_pkg::PH_HALT)  push.ev1.position = serr_nxt;
        else if (phase_nxt == hgsv_pkg::PH_SKIP)  push.ev1.position = skip_nxt;
        else if (phase_nxt != hgsv_pkg::PH_IDLE)  push.ev1.position = cnt_nxt;
        else begin
          push.ev1.event_kind = hgsv_pkg::EV_OK;
          push.ev1.position   = cnt_nxt;
          push.ev1.gene_index = genes_nxt;
        end
        in_comment_nxt = 1'b0;
        cnt_nxt        = '0;
        phase_nxt      = hgsv_pkg::PH_IDLE;
        cls_nxt        = hgsv_pkg::CLS_PLAIN;
        ops_nxt        = 2'd0;
        skip_nxt       = '0;
        bad_nxt        = 1'b0;
        bad_pos_nxt    = '0;
        serr_nxt       = '0;
        genes_nxt      = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_comment_r <= 1'b0;
      cnt_r        <= '0;
      phase_r      <= hgsv_pkg::PH_IDLE;
      cls_r        <= hgsv_pkg::CLS_PLAIN;
      ops_r        <= 2'd0;
      skip_r       <= '0;
      bad_r        <= 1'b0;
      bad_pos_r    <= '0;
      serr_r       <= '0;
      genes_r      <= '0;
    end else begin
      in_comment_r <= in_comment_nxt;
      cnt_r        <= cnt_nxt;
      phase_r      <= phase_nxt;
      cls_r        <= cls_nxt;
      ops_r        <= ops_nxt;
      skip_r       <= skip_nxt;
      bad_r        <= bad_nxt;
      bad_pos_r    <= bad_pos_nxt;
      serr_r       <= serr_nxt;
      genes_r      <= genes_nxt;
    end
  end

  // checks
  `HGSV_ASSERT_NXT(a_last_clears, item_valid && last_char,
    phase_r == hgsv_pkg::PH_IDLE && cnt_r == '0 && !bad_r && !in_comment_r,
    "state not cleared after final byte")
  `HGSV_ASSERT_IMP(a_no_event_after_bad, push.ev0_valid, !bad_r,
    "gene event after bad character")
  `HGSV_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= hgsv_pkg::MAX_POS + 1'b1,
    "stripped count beyond saturation")

endmodule

// ===== rtl/hgsv_queue.sv =====
`timescale 1ns / 1ps
`include "hex_gene_stream_validator_core_assert.svh"

module hgsv_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  hgsv_pkg::push_t    push,
  output logic               room,
  hgsv_out_if.source         out_ch
);

  hgsv_pkg::res_t              mem_r [hgsv_pkg::QDEPTH];
  logic [hgsv_pkg::QAW-1:0]    wp_r, wp_nxt;
  logic [hgsv_pkg::QAW-1:0]    rp_r, rp_nxt;
  logic [hgsv_pkg::QCW-1:0]    cnt_r, cnt_nxt;
  logic [hgsv_pkg::QAW-1:0]    slot1;
  logic [1:0]                  push_n;
  logic                        pop;

  // space for a full pair of words
  assign room   = cnt_r <= hgsv_pkg::QCW'(hgsv_pkg::QDEPTH - 2);
  assign pop    = out_ch.valid && out_ch.ready;
  assign push_n = 2'(push.ev0_valid) + 2'(push.ev1_valid);
  assign slot1  = wp_r + hgsv_pkg::QAW'(push.ev0_valid);

  assign wp_nxt  = wp_r + hgsv_pkg::QAW'(push_n);
  assign rp_nxt  = rp_r + hgsv_pkg::QAW'(pop);
  assign cnt_nxt = cnt_r + hgsv_pkg::QCW'(push_n) - hgsv_pkg::QCW'(pop);

  // head word drives the port
  assign out_ch.valid        = cnt_r != '0;
  assign out_ch.event_kind   = mem_r[rp_r].event_kind;
  assign out_ch.position     = mem_r[rp_r].position;
  assign out_ch.gene_index   = mem_r[rp_r].gene_index;
  assign out_ch.final_result = mem_r[rp_r].final_result;

  // word storage
  always_ff @(posedge clk) begin
    if (push.ev0_valid) mem_r[wp_r]  <= push.ev0;
    if (push.ev1_valid) mem_r[slot1] <= push.ev1;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // checks
  `HGSV_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= hgsv_pkg::QCW'(hgsv_pkg::QDEPTH),
    "queue count out of range")
  `HGSV_ASSERT_IMP(a_push_room, push_n != 2'd0, room,
    "push without room")
  `HGSV_ASSERT_NXT(a_empty_holds, cnt_r == '0 && push_n == 2'd0, cnt_r == '0,
    "empty queue changed without push")

endmodule

// ===== rtl/hex_gene_stream_validator_core.sv =====
`timescale 1ns / 1ps
// channel   dir  payload                                         handshake
// in_ch     in   char_in[7:0], last_char                         valid/ready
// out_ch    out  event_kind[1:0], position[16:0],                valid/ready
//                gene_index[15:0], final_result
//
// one byte accepted per cycle while the queue has room; each byte is held in the
// input register, and its words land in a four-word result queue as it leaves
// a final byte that also closes or opens a gene yields two words; out_ch drains
// one word per ready cycle; in_ch.ready drops with over two waiting and a byte held
// reset: rst_n synchronous, active low; clears parser state and queue pointers
// a stall on out_ch fills the queue, then holds the input register and in_ch.ready

module hex_gene_stream_validator_core (
  input  logic        clk,
  input  logic        rst_n,
  hgsv_in_if.sink     in_ch,
  hgsv_out_if.source  out_ch
);

  logic            in_v_r, in_v_nxt;
  logic [7:0]      char_r;
  logic            last_r;
  logic            room;
  logic            adv;
  logic            acc;
  hgsv_pkg::push_t push;

  // input register moves on when the queue can take a pair of words
  assign adv         = in_v_r && room;
  assign in_ch.ready = !in_v_r || room;
  assign acc         = in_ch.valid && in_ch.ready;
  assign in_v_nxt    = acc ? 1'b1 : (adv ? 1'b0 : in_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) in_v_r <= 1'b0;
    else        in_v_r <= in_v_nxt;
  end

  // input word
  always_ff @(posedge clk) begin
    if (acc) begin
      char_r <= in_ch.char_in;
      last_r <= in_ch.last_char;
    end
  end

  hgsv_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (adv),
    .char_in    (char_r),
    .last_char  (last_r),
    .push       (push)
  );

  hgsv_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
